@@ hw/rtl/kctn_pkg.sv @@
// ----------------------------------------------------------------------------
// kctn_pkg: shared types and constants of the keyed contact table
// Widths, outcome codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package kctn_pkg;

	localparam int MaxEntriesDefault = 16;
	localparam logic [31:0] StaleLimitReset = 32'd60000;

	localparam int KeyW  = 24;
	localparam int DistW = 16;
	localparam int TimeW = 32;
	localparam int PayW  = 64;

	localparam logic OP_UPSERT   = 1'b0;
	localparam logic OP_SNAPSHOT = 1'b1;

	typedef enum logic [2:0] {
		OC_UPDATED  = 3'd0,
		OC_INSERTED = 3'd1,
		OC_REPLACED = 3'd2,
		OC_DROPPED  = 3'd3,
		OC_SNAPSHOT = 3'd4
	} outcome_t;

	typedef struct packed {
		logic       ld_item;     // capture input item
		logic       scan_clr;    // clear scan pointer and search state
		logic       scan_step;   // examine entry at scan pointer
		logic       cmp_step;    // compact: examine entry, copy if kept
		logic       wr_item;     // write item at target slot
		logic       sel_clr;     // start a selection pass (sort output)
		logic       sel_step;    // selection pass: examine one entry
		logic       sel_mark;    // mark chosen entry as emitted
		logic       cnt_inc;
		logic       cnt_from_w;
	} dp_cmd_t;

	typedef struct packed {
		logic       scan_done;   // pointer reached entry count
		logic       found;
		logic       full;
		logic       closer;      // item nearer than farthest entry
		logic       w_zero;      // compacted count is zero
		logic       sel_last;    // emitted count will equal survivors
	} dp_stat_t;

endpackage

@@ hw/rtl/kctn_if.sv @@
// ----------------------------------------------------------------------------
// kctn_in_if / kctn_out_if / kctn_cfg_if: valid/ready channels
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface kctn_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [23:0] contact_key;
	logic [15:0] distance_tenths_km;
	logic [31:0] seen_time_ms;
	logic [63:0] contact_payload;
	logic [31:0] now_ms;
	modport source (output valid, operation, contact_key, distance_tenths_km,
		seen_time_ms, contact_payload, now_ms, input ready);
	modport sink (input valid, operation, contact_key, distance_tenths_km,
		seen_time_ms, contact_payload, now_ms, output ready);
endinterface

interface kctn_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  outcome;
	logic        entry_valid;
	logic [23:0] out_key;
	logic [15:0] out_distance;
	logic [31:0] out_seen_time;
	logic [63:0] out_payload;
	logic        last_result;
	modport source (output valid, outcome, entry_valid, out_key, out_distance,
		out_seen_time, out_payload, last_result, input ready);
	modport sink (input valid, outcome, entry_valid, out_key, out_distance,
		out_seen_time, out_payload, last_result, output ready);
endinterface

interface kctn_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/kctn_datapath.sv @@
// ----------------------------------------------------------------------------
// kctn_datapath: entry storage, scan pointer, compaction and selection
// Storage is per-entry registers; one entry is examined per cycle.
// ----------------------------------------------------------------------------
module kctn_datapath #(
	parameter int MaxEntries = kctn_pkg::MaxEntriesDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kctn_pkg::dp_cmd_t       cmd,
	output kctn_pkg::dp_stat_t      stat,
	input  logic [23:0]             in_key,
	input  logic [15:0]             in_dist,
	input  logic [31:0]             in_seen,
	input  logic [63:0]             in_pay,
	input  logic [31:0]             in_now,
	input  logic [31:0]             stale_limit,
	output logic [23:0]             sel_key,
	output logic [15:0]             sel_dist,
	output logic [31:0]             sel_seen,
	output logic [63:0]             sel_pay
);
	localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
	localparam int CntW = $clog2(MaxEntries + 1);
	localparam logic [CntW-1:0] Full = CntW'(MaxEntries);

	logic [23:0] key_q  [MaxEntries];
	logic [15:0] dist_q [MaxEntries];
	logic [31:0] seen_q [MaxEntries];
	logic [63:0] pay_q  [MaxEntries];

	logic [23:0] it_key_q;
	logic [15:0] it_dist_q;
	logic [31:0] it_seen_q;
	logic [63:0] it_pay_q;
	logic [31:0] it_now_q;

	logic [CntW-1:0] cnt_q, ptr_q, w_q, nsel_q;
	logic [IdxW-1:0] tgt_q, far_q, best_q;
	logic            found_q, have_best_q;
	logic [MaxEntries-1:0] done_q;

	logic [IdxW-1:0] pi;
	logic [IdxW-1:0] wr_idx;
	logic [31:0]     age;
	logic            keep;

	assign pi   = ptr_q[IdxW-1:0];
	assign age  = it_now_q - seen_q[pi];
	assign keep = age <= stale_limit;

	assign stat.scan_done = ptr_q >= cnt_q;
	assign stat.found     = found_q;
	assign stat.full      = cnt_q == Full;
	assign stat.closer    = it_dist_q < dist_q[far_q];
	assign stat.w_zero    = w_q == '0;
	assign stat.sel_last  = (nsel_q + CntW'(1)) == cnt_q;

	// full table without a key match writes over the farthest entry
	assign wr_idx = (found_q || !stat.full) ? tgt_q : far_q;

	assign sel_key  = key_q[best_q];
	assign sel_dist = dist_q[best_q];
	assign sel_seen = seen_q[best_q];
	assign sel_pay  = pay_q[best_q];

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			it_key_q  <= in_key;
			it_dist_q <= in_dist;
			it_seen_q <= in_seen;
			it_pay_q  <= in_pay;
			it_now_q  <= in_now;
		end
		if (cmd.cmp_step && keep) begin
			key_q[w_q[IdxW-1:0]]  <= key_q[pi];
			dist_q[w_q[IdxW-1:0]] <= dist_q[pi];
			seen_q[w_q[IdxW-1:0]] <= seen_q[pi];
			pay_q[w_q[IdxW-1:0]]  <= pay_q[pi];
		end
		if (cmd.wr_item) begin
			key_q[wr_idx]  <= it_key_q;
			dist_q[wr_idx] <= it_dist_q;
			seen_q[wr_idx] <= it_seen_q;
			pay_q[wr_idx]  <= it_pay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
			w_q <= '0;
			nsel_q <= '0;
			tgt_q <= '0;
			far_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			have_best_q <= 1'b0;
			done_q <= '0;
		end else begin
			if (cmd.scan_clr) begin
				ptr_q <= '0;
				w_q <= '0;
				found_q <= 1'b0;
				far_q <= '0;
				tgt_q <= cnt_q[IdxW-1:0];
			end
			if (cmd.scan_step && !found_q) begin
				if (key_q[pi] == it_key_q) begin
					found_q <= 1'b1;
					tgt_q <= pi;
				end else if (dist_q[pi] > dist_q[far_q]) begin
					far_q <= pi;
				end
				ptr_q <= ptr_q + CntW'(1);
			end
			if (cmd.cmp_step) begin
				if (keep) w_q <= w_q + CntW'(1);
				ptr_q <= ptr_q + CntW'(1);
			end
			if (cmd.cnt_inc) cnt_q <= cnt_q + CntW'(1);
			if (cmd.cnt_from_w) begin
				cnt_q <= w_q;
				done_q <= '0;
				nsel_q <= '0;
			end
			if (cmd.sel_clr) begin
				ptr_q <= '0;
				have_best_q <= 1'b0;
			end
			// first strictly smaller undone entry wins: stable order
			if (cmd.sel_step) begin
				if (!done_q[pi] && (!have_best_q || dist_q[pi] < dist_q[best_q])) begin
					best_q <= pi;
					have_best_q <= 1'b1;
				end
				ptr_q <= ptr_q + CntW'(1);
			end
			if (cmd.sel_mark) begin
				done_q[best_q] <= 1'b1;
				nsel_q <= nsel_q + CntW'(1);
			end
		end
	end
endmodule

@@ hw/rtl/kctn_ctrl.sv @@
// ----------------------------------------------------------------------------
// kctn_ctrl: controller state machine
// Sequences scan, write, compaction and selection passes; owns result reg.
// ----------------------------------------------------------------------------
module kctn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         outcome,
	output logic               entry_valid,
	output logic               last_result,
	output logic               ld_sel,
	output logic               ld_res,
	output kctn_pkg::dp_cmd_t  cmd,
	input  kctn_pkg::dp_stat_t stat
);
	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_COMPACT, S_SEL, S_EMIT, S_WAIT
	} state_t;

	state_t state_q;
	logic   in_xfer, out_free;

	assign in_ready = state_q == S_IDLE;
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	// a result enters the output register this cycle
	assign ld_res   = ((state_q == S_DECIDE) || (state_q == S_EMIT)) && out_free;

	always_comb begin
		cmd = '0;
		ld_sel = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ld_item = in_xfer;
				cmd.scan_clr = in_xfer;
			end
			S_SCAN: cmd.scan_step = !stat.scan_done;
			S_DECIDE: if (out_free) begin
				if (stat.found || !stat.full || stat.closer) cmd.wr_item = 1'b1;
				if (!stat.found && !stat.full) cmd.cnt_inc = 1'b1;
			end
			S_COMPACT: begin
				cmd.cmp_step = !stat.scan_done;
				cmd.cnt_from_w = stat.scan_done;
				cmd.sel_clr = stat.scan_done;
			end
			S_SEL: cmd.sel_step = !stat.scan_done;
			S_EMIT: if (out_free) begin
				ld_sel = 1'b1;
				cmd.sel_mark = 1'b1;
				cmd.sel_clr = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			outcome <= kctn_pkg::OC_UPDATED;
			entry_valid <= 1'b0;
			last_result <= 1'b0;
		end else begin
			if (out_valid && out_ready && !ld_res) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_xfer) begin
					state_q <= (in_op == kctn_pkg::OP_SNAPSHOT) ? S_COMPACT : S_SCAN;
				end
				S_SCAN: if (stat.scan_done || stat.found) state_q <= S_DECIDE;
				S_DECIDE: if (out_free) begin
					out_valid <= 1'b1;
					entry_valid <= 1'b0;
					last_result <= 1'b1;
					if (stat.found) outcome <= kctn_pkg::OC_UPDATED;
					else if (!stat.full) outcome <= kctn_pkg::OC_INSERTED;
					else if (stat.closer) outcome <= kctn_pkg::OC_REPLACED;
					else outcome <= kctn_pkg::OC_DROPPED;
					state_q <= S_IDLE;
				end
				S_COMPACT: if (stat.scan_done) state_q <= S_SEL;
				S_SEL: if (stat.scan_done) state_q <= S_EMIT;
				S_EMIT: if (out_free) begin
					out_valid <= 1'b1;
					outcome <= kctn_pkg::OC_SNAPSHOT;
					entry_valid <= !stat.w_zero;
					last_result <= stat.w_zero || stat.sel_last;
					state_q <= (stat.w_zero || stat.sel_last) ? S_IDLE : S_SEL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/keyed_contact_table_nearest_keep.sv @@
// ----------------------------------------------------------------------------
// keyed_contact_table_nearest_keep: bounded nearest-contact table
// Upsert by 24-bit key with farthest-entry replacement; aged, sorted snapshot.
// ----------------------------------------------------------------------------
// Channels: in (items), out (results), cfg (stale limit write, reset 60000).
// One item at a time: in.ready is high only while the block is idle.
// Upsert: key scan of one entry per cycle, then one result.
// Snapshot: compaction pass, then for each survivor a selection pass over
//   the table and the emit of the nearest remaining entry; an empty table
//   gives one invalid result.
// The per-entry selection pass over the register file sets the snapshot rate.
// Results sit in an output register; while the receiver stalls, the block
// holds and continues once the register is taken.
// Reset empties the table (entry count zero) and restores the stale limit.
// Entry contents are not cleared; entries beyond the count are never read.
// ----------------------------------------------------------------------------
module keyed_contact_table_nearest_keep #(
	parameter int MaxEntries = kctn_pkg::MaxEntriesDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	kctn_in_if.sink       in,
	kctn_out_if.source    out,
	kctn_cfg_if.sink      cfg
);
	logic [31:0] stale_q;
	kctn_pkg::dp_cmd_t  cmd;
	kctn_pkg::dp_stat_t stat;
	logic ld_sel;
	logic ld_res;
	logic [23:0] sk;
	logic [15:0] sd;
	logic [31:0] ss;
	logic [63:0] sp;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stale_q <= kctn_pkg::StaleLimitReset;
		else if (cfg.valid) stale_q <= cfg.data;
	end

	kctn_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in.valid), .in_op(in.operation), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.outcome(out.outcome), .entry_valid(out.entry_valid),
		.last_result(out.last_result), .ld_sel, .ld_res, .cmd, .stat
	);

	kctn_datapath #(.MaxEntries(MaxEntries)) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_key(in.contact_key),
		.in_dist(in.distance_tenths_km), .in_seen(in.seen_time_ms),
		.in_pay(in.contact_payload), .in_now(in.now_ms), .stale_limit(stale_q),
		.sel_key(sk), .sel_dist(sd), .sel_seen(ss), .sel_pay(sp)
	);

	// entry fields are zero unless a real entry is emitted
	always_ff @(posedge clk) begin
		if (ld_sel && !stat.w_zero) begin
			out.out_key <= sk;
			out.out_distance <= sd;
			out.out_seen_time <= ss;
			out.out_payload <= sp;
		end else if (ld_res) begin
			out.out_key <= '0;
			out.out_distance <= '0;
			out.out_seen_time <= '0;
			out.out_payload <= '0;
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid) else $error("result lost");
	a_last_on_upsert: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.outcome != kctn_pkg::OC_SNAPSHOT
			|-> out.last_result && !out.entry_valid)
		else $error("upsert result malformed");
	a_snap_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.entry_valid |-> out.last_result) else $error("invalid not last");
`endif
endmodule

@@ tb/tb_channels.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_channels: testbench-side helpers for the contact table channels
// Result record used by the scoreboard and stimulus row record of the testbench.
// ----------------------------------------------------------------------------
package tb_contact_pkg;

	typedef struct {
		kctn_pkg::outcome_t outcome;
		logic        entry_valid;
		logic [23:0] key;
		logic [15:0] distance;
		logic [31:0] seen;
		logic [63:0] payload;
		logic        last;
	} contact_result_t;

	typedef struct {
		logic        op;
		logic [23:0] key;
		logic [15:0] distance;
		logic [31:0] seen;
		logic [63:0] payload;
		logic [31:0] now;
		logic        has_result;
		kctn_pkg::outcome_t outcome;
	} contact_row_t;
endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: keyed contact table self-checking bench
// Directed table then random upserts/snapshots; results scored against a
// behavioral copy of the table, under varying source and sink idling.
// ----------------------------------------------------------------------------
module testbench;

	localparam int Depth = 16;
	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	kctn_in_if  in_ch();
	kctn_out_if out_ch();
	kctn_cfg_if cfg_ch();

	keyed_contact_table_nearest_keep dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
	);

	// model of the table
	logic [23:0] tbl_key [Depth];
	logic [15:0] tbl_dist [Depth];
	logic [31:0] tbl_seen [Depth];
	logic [63:0] tbl_pay [Depth];
	int          tbl_count;
	logic [31:0] stale_limit;

	tb_contact_pkg::contact_result_t pending_results[$];
	int  errors = 0;
	int  results_seen = 0;
	int  items_sent = 0;
	int  snapshots_sent = 0;
	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	longint cycles = 0;
	logic [23:0] recent_keys[$];

	function automatic tb_contact_pkg::contact_result_t mk_result(kctn_pkg::outcome_t oc,
			logic ev, logic [23:0] k, logic [15:0] d, logic [31:0] s, logic [63:0] p,
			logic l);
		tb_contact_pkg::contact_result_t r;
		r.outcome = oc; r.entry_valid = ev; r.key = k; r.distance = d;
		r.seen = s; r.payload = p; r.last = l;
		return r;
	endfunction

	task automatic predict_table(input tb_contact_pkg::contact_row_t it);
		int i, j, w, far, slot, cur;
		int order[Depth];
		kctn_pkg::outcome_t oc;
		logic [31:0] age;
		if (it.op == kctn_pkg::OP_UPSERT) begin
			slot = -1;
			for (i = 0; i < tbl_count; i++)
				if (slot < 0 && tbl_key[i] == it.key) slot = i;
			if (slot >= 0) begin
				oc = kctn_pkg::OC_UPDATED;
			end else if (tbl_count < Depth) begin
				slot = tbl_count;
				tbl_count++;
				oc = kctn_pkg::OC_INSERTED;
			end else begin
				far = 0;
				for (i = 1; i < tbl_count; i++)
					if (tbl_dist[i] > tbl_dist[far]) far = i;
				if (it.distance < tbl_dist[far]) begin
					slot = far;
					oc = kctn_pkg::OC_REPLACED;
				end else begin
					oc = kctn_pkg::OC_DROPPED;
				end
			end
			if (slot >= 0) begin
				tbl_key[slot] = it.key; tbl_dist[slot] = it.distance;
				tbl_seen[slot] = it.seen; tbl_pay[slot] = it.payload;
			end
			pending_results.push_back(mk_result(oc, 1'b0, '0, '0, '0, '0, 1'b1));
		end else begin
			w = 0;
			for (i = 0; i < tbl_count; i++) begin
				age = it.now - tbl_seen[i];
				if (age <= stale_limit) begin
					tbl_key[w] = tbl_key[i]; tbl_dist[w] = tbl_dist[i];
					tbl_seen[w] = tbl_seen[i]; tbl_pay[w] = tbl_pay[i];
					w++;
				end
			end
			tbl_count = w;
			if (w == 0) begin
				pending_results.push_back(mk_result(kctn_pkg::OC_SNAPSHOT, 1'b0,
					'0, '0, '0, '0, 1'b1));
			end else begin
				for (i = 0; i < w; i++) order[i] = i;
				// stable insertion sort, nearest first
				for (i = 1; i < w; i++) begin
					cur = order[i];
					j = i;
					while (j > 0 && tbl_dist[order[j-1]] > tbl_dist[cur]) begin
						order[j] = order[j-1];
						j--;
					end
					order[j] = cur;
				end
				for (i = 0; i < w; i++)
					pending_results.push_back(mk_result(kctn_pkg::OC_SNAPSHOT, 1'b1,
						tbl_key[order[i]], tbl_dist[order[i]], tbl_seen[order[i]],
						tbl_pay[order[i]], (i == w - 1)));
			end
		end
	endtask

	// sink side: random ready, check at rising edge
	always @(posedge clk) begin
		tb_contact_pkg::contact_result_t e;
		cycles <= cycles + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result outcome=%0d key=%h", $time,
					out_ch.outcome, out_ch.out_key);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_ch.outcome !== e.outcome || out_ch.entry_valid !== e.entry_valid ||
						out_ch.out_key !== e.key || out_ch.out_distance !== e.distance ||
						out_ch.out_seen_time !== e.seen || out_ch.out_payload !== e.payload ||
						out_ch.last_result !== e.last) begin
					$display("%0t: mismatch expected oc=%0d v=%b k=%h d=%h s=%h p=%h l=%b",
						$time, e.outcome, e.entry_valid, e.key, e.distance, e.seen,
						e.payload, e.last);
					$display("%0t:          actual oc=%0d v=%b k=%h d=%h s=%h p=%h l=%b",
						$time, out_ch.outcome, out_ch.entry_valid, out_ch.out_key,
						out_ch.out_distance, out_ch.out_seen_time, out_ch.out_payload,
						out_ch.last_result);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input tb_contact_pkg::contact_row_t it);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) @(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.operation <= it.op;
		in_ch.contact_key <= it.key;
		in_ch.distance_tenths_km <= it.distance;
		in_ch.seen_time_ms <= it.seen;
		in_ch.contact_payload <= it.payload;
		in_ch.now_ms <= it.now;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_table(it);
		items_sent++;
		if (it.op == kctn_pkg::OP_SNAPSHOT) snapshots_sent++;
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic drain_and_config(input logic [31:0] val);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		stale_limit = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic tb_contact_pkg::contact_row_t row(logic op, logic [23:0] k,
			logic [15:0] d, logic [31:0] s, logic [63:0] p, logic [31:0] n, logic hr,
			kctn_pkg::outcome_t oc);
		tb_contact_pkg::contact_row_t r;
		r.op = op; r.key = k; r.distance = d; r.seen = s; r.payload = p; r.now = n;
		r.has_result = hr; r.outcome = oc;
		return r;
	endfunction

	function automatic tb_contact_pkg::contact_row_t random_row(int snap_pct,
			logic [31:0] base_now);
		tb_contact_pkg::contact_row_t r;
		r.op = ($urandom_range(99) < snap_pct) ? kctn_pkg::OP_SNAPSHOT : kctn_pkg::OP_UPSERT;
		if (recent_keys.size() != 0 && $urandom_range(2) == 0)
			r.key = recent_keys[$urandom_range(recent_keys.size() - 1)];
		else
			r.key = 24'($urandom);
		case ($urandom_range(4))
			0: r.distance = 16'hFFFF;
			1: r.distance = 16'($urandom_range(20));
			default: r.distance = 16'($urandom);
		endcase
		r.seen = base_now - $urandom_range(120000);
		if ($urandom_range(9) == 0) r.seen = $urandom;
		r.payload = {$urandom, $urandom};
		r.now = base_now;
		r.has_result = 1'b0;
		r.outcome = kctn_pkg::OC_UPDATED;
		return r;
	endfunction

	tb_contact_pkg::contact_row_t directed[$];
	tb_contact_pkg::contact_row_t it;
	int phase, n, k;
	logic [31:0] clock_ms;

	initial begin
		in_ch.valid = 1'b0; in_ch.operation = 1'b0; in_ch.contact_key = '0;
		in_ch.distance_tenths_km = '0; in_ch.seen_time_ms = '0;
		in_ch.contact_payload = '0; in_ch.now_ms = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0; cfg_ch.data = '0;
		tbl_count = 0;
		stale_limit = kctn_pkg::StaleLimitReset;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty snapshot, extremes, fill to full, replace, drop, wrap
		directed.push_back(row(kctn_pkg::OP_SNAPSHOT, 0, 0, 0, 0, 1000, 1,
			kctn_pkg::OC_SNAPSHOT));
		directed.push_back(row(kctn_pkg::OP_UPSERT, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF,
			64'hFFFFFFFFFFFFFFFF, 0, 1, kctn_pkg::OC_INSERTED));
		directed.push_back(row(kctn_pkg::OP_UPSERT, 24'h000000, 16'h0000, 32'd0, 64'd0,
			0, 1, kctn_pkg::OC_INSERTED));
		directed.push_back(row(kctn_pkg::OP_UPSERT, 24'hFFFFFF, 16'h0005, 32'd100,
			64'h0123456789ABCDEF, 0, 1, kctn_pkg::OC_UPDATED));
		for (k = 0; k < 14; k++)
			directed.push_back(row(kctn_pkg::OP_UPSERT, 24'h100 + 24'(k),
				16'd1000 + 16'(k % 3), 32'd50 + k, {32'hA5A5A5A5, 32'(k)}, 0, 1,
				kctn_pkg::OC_INSERTED));
		directed.push_back(row(kctn_pkg::OP_UPSERT, 24'h5A5A5A, 16'd999, 32'd200, 64'd7,
			0, 1, kctn_pkg::OC_REPLACED));
		directed.push_back(row(kctn_pkg::OP_UPSERT, 24'h6B6B6B, 16'hFFFF, 32'd200, 64'd8,
			0, 1, kctn_pkg::OC_DROPPED));
		directed.push_back(row(kctn_pkg::OP_SNAPSHOT, 0, 0, 0, 0, 32'd60050, 0,
			kctn_pkg::OC_SNAPSHOT));
		// entry seen after now: wraps to a huge age and is aged out
		directed.push_back(row(kctn_pkg::OP_UPSERT, 24'h777777, 16'd3, 32'd70000, 64'd9,
			0, 0, kctn_pkg::OC_INSERTED));
		directed.push_back(row(kctn_pkg::OP_SNAPSHOT, 0, 0, 0, 0, 32'd60100, 0,
			kctn_pkg::OC_SNAPSHOT));

		foreach (directed[i]) begin
			send_item(directed[i]);
			// typed-in expectation cross-checks the predictor on obvious rows
			if (directed[i].has_result && pending_results.size() != 0 &&
					pending_results[$].outcome !== directed[i].outcome) begin
				$display("%0t: directed row %0d expected outcome %0d, predictor %0d",
					$time, i, directed[i].outcome, pending_results[$].outcome);
				errors++;
			end
		end

		clock_ms = 32'd1000000;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin src_idle_pct = 31; snk_idle_pct = 51; drain_and_config(32'd0); end
				1: begin
					src_idle_pct = 51; snk_idle_pct = 31;
					drain_and_config(32'hFFFFFFFF);
				end
				default: begin
					src_idle_pct = 0; snk_idle_pct = 0;
					drain_and_config(32'd60000);
				end
			endcase
			// random upserts and snapshots under the new stale limit
			for (n = 0; n < 53; n++) begin
				clock_ms = clock_ms + $urandom_range(5000);
				it = random_row(12, clock_ms);
				if (it.op == kctn_pkg::OP_UPSERT) begin
					recent_keys.push_back(it.key);
					if (recent_keys.size() > 24) void'(recent_keys.pop_front());
				end
				send_item(it);
			end
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d items (%0d snapshots), checked %0d results",
			items_sent, snapshots_sent, results_seen);
		$display("Stale limits covered: 0, max, 60000 and reset value");
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
